// ===== hdl/button_event_queue_autorepeat_core_macros.svh =====
// Assertion macros used by the checker file of the button queue block.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef BUTTON_EVENT_QUEUE_AUTOREPEAT_CORE_MACROS_SVH
`define BUTTON_EVENT_QUEUE_AUTOREPEAT_CORE_MACROS_SVH

// Same-cycle implication under an active-low reset
`define BEQA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("button queue check failed");

// Delayed implication under an active-low reset
`define BEQA_ASSERT_IMP2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
		else $error("button queue latency check failed");

`endif

// ===== hdl/beqa_pkg.sv =====
// Package for the button press queue with auto-repeat: types, codes, sizes.
// No dependencies; used by scoped names from the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package beqa_pkg;

	// Queue sizing and derived widths
	localparam int QUEUE_DEPTH = 4;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Field widths
	localparam int FUNC_W  = 2;
	localparam int PINS_W  = 4;
	localparam int BTN_W   = 2;
	localparam int OUT_W   = 3;
	localparam int DELAY_W = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [DELAY_W-1:0] RESET_INITIAL_DELAY = 16'd300;
	localparam logic [DELAY_W-1:0] RESET_REPEAT_DELAY  = 16'd400;
	localparam logic [PINS_W-1:0]  PIN_MASK            = 4'hF;
	localparam logic signed [OUT_W-1:0] NO_BUTTON       = -3'sd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 1'd1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK = 2'd0,
		FUNC_PIN  = 2'd1,
		FUNC_POP  = 2'd2,
		FUNC_POLL = 2'd3
	} func_t;

	typedef logic [BTN_W-1:0] btn_t;

	// Decode of a pin pattern: valid only for exactly one bit set
	typedef struct packed {
		logic hit;
		btn_t idx;
	} onehot_t;

	function automatic onehot_t onehot_index(input logic [PINS_W-1:0] p);
		onehot_t r;
		r = '0;
		unique case (p)
			4'h1: r = '{hit: 1'b1, idx: 2'd0};
			4'h2: r = '{hit: 1'b1, idx: 2'd1};
			4'h4: r = '{hit: 1'b1, idx: 2'd2};
			4'h8: r = '{hit: 1'b1, idx: 2'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/button_event_queue_autorepeat_core.sv =====
// Top level of the four-button press queue with typematic auto-repeat.
// Depends on beqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Use of the block
//   Items: drive func and pins with start high; an item transfers at a rising
//   edge with start high and busy low. busy stays low, so one item may be
//   given every cycle.
//   Results: exactly one per item, shown for one cycle with done high on
//   button (signed, -1 for none) and queued. The receiver cannot stall, so
//   it has to take every result in the cycle it is shown.
//   Path: an item passes an input register, then the result register.
//   Throughput is one item per cycle; the state update is one pass of logic
//   between them.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is the initial repeat delay, index 1 the repeat interval (milliseconds).
//   cfg_ready is always high; write only while no item is in flight.
//   Reset: arst_n low clears the counter, queue count, remembered pins and
//   deadline (disarmed) and loads delays of 300 and 400. Queue entries are
//   not cleared; only written entries are ever read.
module button_event_queue_autorepeat_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output      logic                                  busy,
	input  wire logic [beqa_pkg::FUNC_W-1:0]           func,
	input  wire logic [beqa_pkg::PINS_W-1:0]           pins,
	output      logic                                  done,
	output      logic signed [beqa_pkg::OUT_W-1:0]     button,
	output      logic [beqa_pkg::OUT_W-1:0]            queued,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [beqa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [beqa_pkg::DELAY_W-1:0]          cfg_data
);

	// Input register
	logic                              valid_s1;
	beqa_pkg::func_t                   func_s1;
	logic [beqa_pkg::PINS_W-1:0]       pins_s1;

	// Block state
	beqa_pkg::btn_t                    queue_q [beqa_pkg::QUEUE_DEPTH];
	logic [beqa_pkg::COUNT_W-1:0]      count_q;
	logic [beqa_pkg::PINS_W-1:0]       last_pins_q;
	logic [beqa_pkg::TIME_W-1:0]       deadline_q;
	logic [beqa_pkg::TIME_W-1:0]       now_q;
	logic [beqa_pkg::DELAY_W-1:0]      init_delay_q;
	logic [beqa_pkg::DELAY_W-1:0]      rpt_delay_q;

	// Result register
	logic                              done_q;
	logic signed [beqa_pkg::OUT_W-1:0] button_q;
	logic [beqa_pkg::OUT_W-1:0]        queued_q;

	// Next-state terms
	beqa_pkg::onehot_t                 hot;
	logic                              enq;
	logic                              pop;
	logic [beqa_pkg::COUNT_W-1:0]      count_nxt;
	logic [beqa_pkg::PINS_W-1:0]       last_pins_nxt;
	logic [beqa_pkg::TIME_W-1:0]       deadline_nxt;
	logic [beqa_pkg::TIME_W-1:0]       now_nxt;
	logic signed [beqa_pkg::OUT_W-1:0] button_nxt;
	logic [beqa_pkg::TIME_W-1:0]       init_sum;
	logic [beqa_pkg::TIME_W-1:0]       rpt_sum;
	logic                              not_full;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign button    = button_q;
	assign queued    = queued_q;

	// Capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1 <= beqa_pkg::func_t'(func);
			pins_s1 <= pins & beqa_pkg::PIN_MASK;
		end
	end

	// One pass over the item
	assign hot      = beqa_pkg::onehot_index(pins_s1);
	assign init_sum = now_q + {{(beqa_pkg::TIME_W-beqa_pkg::DELAY_W){1'b0}}, init_delay_q};
	assign rpt_sum  = now_q + {{(beqa_pkg::TIME_W-beqa_pkg::DELAY_W){1'b0}}, rpt_delay_q};
	assign not_full = count_q < beqa_pkg::COUNT_W'(beqa_pkg::QUEUE_DEPTH);

	always_comb begin
		enq           = 1'b0;
		pop           = 1'b0;
		count_nxt     = count_q;
		last_pins_nxt = last_pins_q;
		deadline_nxt  = deadline_q;
		now_nxt       = now_q;
		button_nxt    = beqa_pkg::NO_BUTTON;
		unique case (func_s1)
			beqa_pkg::FUNC_TICK: begin
				now_nxt = now_q + beqa_pkg::TIME_W'(1);
			end
			beqa_pkg::FUNC_PIN: begin
				if (not_full) begin
					if (hot.hit) begin
						enq          = 1'b1;
						count_nxt    = count_q + beqa_pkg::COUNT_W'(1);
						deadline_nxt = init_sum;
					end else begin
						deadline_nxt = '0;
					end
				end
				last_pins_nxt = pins_s1;
			end
			beqa_pkg::FUNC_POP: begin
				if (count_q != '0) begin
					pop        = 1'b1;
					count_nxt  = count_q - beqa_pkg::COUNT_W'(1);
					button_nxt = {1'b0, queue_q[0]};
				end
			end
			beqa_pkg::FUNC_POLL: begin
				// Repeat only while armed, the same single pin held and the deadline passed
				if (deadline_q != '0) begin
					if (pins_s1 != last_pins_q) begin
						deadline_nxt = '0;
					end else if (now_q > deadline_q) begin
						if (hot.hit) begin
							button_nxt   = {1'b0, hot.idx};
							deadline_nxt = rpt_sum;
						end else begin
							deadline_nxt = '0;
						end
					end
				end
			end
			default: begin
				now_nxt = now_q;
			end
		endcase
	end

	// Control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_pins_q <= '0;
			deadline_q  <= '0;
			now_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				count_q     <= count_nxt;
				last_pins_q <= last_pins_nxt;
				deadline_q  <= deadline_nxt;
				now_q       <= now_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			button_q <= button_nxt;
			queued_q <= beqa_pkg::OUT_W'(count_nxt);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_delay_q <= beqa_pkg::RESET_INITIAL_DELAY;
			rpt_delay_q  <= beqa_pkg::RESET_REPEAT_DELAY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				beqa_pkg::CFG_INITIAL_DELAY: init_delay_q <= cfg_data;
				beqa_pkg::CFG_REPEAT_DELAY:  rpt_delay_q  <= cfg_data;
				default:                     init_delay_q <= init_delay_q;
			endcase
		end
	end

	// Queue entries: write at the tail, shift towards the head on pop
	always_ff @(posedge clk) begin
		if (valid_s1 && enq) begin
			queue_q[count_q[beqa_pkg::IDX_W-1:0]] <= hot.idx;
		end else if (valid_s1 && pop) begin
			for (int i = 0; i < beqa_pkg::QUEUE_DEPTH - 1; i++) begin
				queue_q[i] <= queue_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/beqa_checker.sv =====
// Port-level checker for the button queue core, attached by bind.
// Depends on beqa_pkg and button_event_queue_autorepeat_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "button_event_queue_autorepeat_core_macros.svh"

module beqa_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic signed [beqa_pkg::OUT_W-1:0] button,
	input wire logic [beqa_pkg::OUT_W-1:0]        queued
);

	// Every transfer gives its result through the input and result registers
	`BEQA_ASSERT_IMP2(a_result_follows, clk, arst_n, start && !busy, done)

	// No result without a matching earlier transfer
	`BEQA_ASSERT_IMP(a_no_spurious, clk, arst_n, !$past(start && !busy, 2), !done)

	// A reported button is none or a real button index
	`BEQA_ASSERT_IMP(a_button_range, clk, arst_n, done,
		(button == beqa_pkg::NO_BUTTON) || !button[beqa_pkg::OUT_W-1])

	// The queue never reports more presses than its depth
	`BEQA_ASSERT_IMP(a_queued_range, clk, arst_n, done,
		queued <= beqa_pkg::OUT_W'(beqa_pkg::QUEUE_DEPTH))

endmodule

bind button_event_queue_autorepeat_core beqa_checker u_beqa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.button (button),
	.queued (queued)
);

`default_nettype wire

// ===== sim/tb_button_event_queue_autorepeat_core.sv =====
// Self-checking testbench for the four-button press queue with auto-repeat.
// Drives items and register writes, predicts each result and compares it.
// Depends on beqa_pkg and button_event_queue_autorepeat_core.
`timescale 1ns / 1ps

module tb_button_event_queue_autorepeat_core;

	typedef struct {
		logic signed [beqa_pkg::OUT_W-1:0] button;
		logic [beqa_pkg::OUT_W-1:0]        queued;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [beqa_pkg::FUNC_W-1:0] func;
	logic [beqa_pkg::PINS_W-1:0] pins;
	logic done;
	logic signed [beqa_pkg::OUT_W-1:0] button;
	logic [beqa_pkg::OUT_W-1:0] queued;
	logic cfg_valid;
	logic cfg_ready;
	logic [beqa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [beqa_pkg::DELAY_W-1:0] cfg_data;

	// Predicted block state
	beqa_pkg::btn_t              held_presses[$];
	logic [beqa_pkg::PINS_W-1:0] pins_seen;
	logic [beqa_pkg::TIME_W-1:0] deadline_ms;
	logic [beqa_pkg::TIME_W-1:0] ms_now;
	logic [beqa_pkg::DELAY_W-1:0] first_repeat_ms;
	logic [beqa_pkg::DELAY_W-1:0] repeat_gap_ms;

	// Reports waiting for the block, oldest first
	report_t pending_reports[$];

	int fail_count = 0;
	int n_items = 0;
	int n_repeats = 0;
	int n_pops = 0;
	int n_cfg = 0;
	int burst_left = 0;

	button_event_queue_autorepeat_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.pins      (pins),
		.done      (done),
		.button    (button),
		.queued    (queued),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("timeout: block stopped responding");
		$display("*** FAILED ***");
		$finish;
	end

	// Index of a single pressed pin, -1 when none or several are set
	function automatic int pressed_index(logic [beqa_pkg::PINS_W-1:0] p);
		for (int b = 0; b < beqa_pkg::PINS_W; b++)
			if (p == (beqa_pkg::PINS_W'(1) << b))
				return b;
		return -1;
	endfunction

	// Applies one item to the predicted state and returns its report
	function automatic report_t next_button_report(beqa_pkg::func_t f,
		logic [beqa_pkg::PINS_W-1:0] p);
		report_t r;
		int idx;
		idx = pressed_index(p);
		r.button = beqa_pkg::NO_BUTTON;
		case (f)
			beqa_pkg::FUNC_TICK: ms_now = ms_now + 1;
			beqa_pkg::FUNC_PIN: begin
				if (held_presses.size() < beqa_pkg::QUEUE_DEPTH) begin
					if (idx >= 0) begin
						held_presses.push_back(beqa_pkg::btn_t'(idx));
						deadline_ms = ms_now + beqa_pkg::TIME_W'(first_repeat_ms);
					end else begin
						deadline_ms = '0;
					end
				end
				pins_seen = p;
			end
			beqa_pkg::FUNC_POP: begin
				if (held_presses.size() > 0) begin
					r.button = beqa_pkg::OUT_W'(held_presses.pop_front());
					n_pops++;
				end
			end
			beqa_pkg::FUNC_POLL: begin
				if (deadline_ms != '0) begin
					if (p != pins_seen) begin
						deadline_ms = '0;
					end else if (ms_now > deadline_ms) begin
						if (idx >= 0) begin
							r.button = beqa_pkg::OUT_W'(idx);
							deadline_ms = ms_now + beqa_pkg::TIME_W'(repeat_gap_ms);
							n_repeats++;
						end else begin
							deadline_ms = '0;
						end
					end
				end
			end
		endcase
		r.queued = beqa_pkg::OUT_W'(held_presses.size());
		return r;
	endfunction

	// Result checker: every done cycle is one transfer out of the block
	always @(posedge clk) begin
		report_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("result with no item outstanding: button %0d queued %0d",
					button, queued);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (button !== want.button) begin
					$error("button: expected %0d, got %0d", want.button, button);
					fail_count++;
				end
				if (queued !== want.queued) begin
					$error("queued: expected %0d, got %0d", want.queued, queued);
					fail_count++;
				end
			end
		end
	end

	// One item transfer; returns at the accepting edge with start still high
	task automatic send_item(beqa_pkg::func_t f, logic [beqa_pkg::PINS_W-1:0] p);
		start <= 1'b1;
		func  <= f;
		pins  <= p;
		do @(posedge clk); while (busy !== 1'b0);
		pending_reports.push_back(next_button_report(f, p));
		n_items++;
	endtask

	// Sender in bursts with random gaps between them
	task automatic send_paced(beqa_pkg::func_t f, logic [beqa_pkg::PINS_W-1:0] p);
		send_item(f, p);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Hold the sender until every report is back, then idle before returning
	task automatic drain_reports();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [beqa_pkg::CFG_IDX_W-1:0] idx,
		logic [beqa_pkg::DELAY_W-1:0] data);
		drain_reports();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == beqa_pkg::CFG_INITIAL_DELAY)
			first_repeat_ms = data;
		else
			repeat_gap_ms = data;
		n_cfg++;
	endtask

	task automatic ticks(int n);
		repeat (n) send_paced(beqa_pkg::FUNC_TICK, beqa_pkg::PINS_W'($urandom));
	endtask

	// At time zero a zero initial delay gives a zero deadline, which stays
	// disarmed; later the reset repeat interval of 400 is timed out
	task automatic test_zero_deadline_and_reset_interval();
		cfg_write(beqa_pkg::CFG_INITIAL_DELAY, '0);
		send_paced(beqa_pkg::FUNC_POP, 4'hF);
		send_paced(beqa_pkg::FUNC_POLL, 4'h0);
		send_paced(beqa_pkg::FUNC_PIN, 4'h1);
		ticks(1);
		send_paced(beqa_pkg::FUNC_POLL, 4'h1);
		send_paced(beqa_pkg::FUNC_PIN, 4'h1);
		ticks(1);
		send_paced(beqa_pkg::FUNC_POLL, 4'h1);
		ticks(400);
		send_paced(beqa_pkg::FUNC_POLL, 4'h1);
		ticks(1);
		send_paced(beqa_pkg::FUNC_POLL, 4'h1);
		send_paced(beqa_pkg::FUNC_POP, 4'h0);
		send_paced(beqa_pkg::FUNC_POP, 4'h0);
		send_paced(beqa_pkg::FUNC_PIN, 4'h0);
	endtask

	// Full queue: presses dropped, deadline kept, pins still remembered
	task automatic test_queue_full();
		cfg_write(beqa_pkg::CFG_INITIAL_DELAY, 16'd3);
		cfg_write(beqa_pkg::CFG_REPEAT_DELAY, 16'd2);
		send_paced(beqa_pkg::FUNC_PIN, 4'h1);
		send_paced(beqa_pkg::FUNC_PIN, 4'h2);
		send_paced(beqa_pkg::FUNC_PIN, 4'h4);
		send_paced(beqa_pkg::FUNC_PIN, 4'h8);
		send_paced(beqa_pkg::FUNC_PIN, 4'h1);
		send_paced(beqa_pkg::FUNC_PIN, 4'h3);
		ticks(4);
		send_paced(beqa_pkg::FUNC_POLL, 4'h3);
		send_paced(beqa_pkg::FUNC_POLL, 4'h3);
		repeat (5) send_paced(beqa_pkg::FUNC_POP, 4'hA);
	endtask

	// Repeat polls: early, changed pins, held and released
	task automatic test_repeat_polls();
		cfg_write(beqa_pkg::CFG_INITIAL_DELAY, 16'd2);
		cfg_write(beqa_pkg::CFG_REPEAT_DELAY, 16'd1);
		send_paced(beqa_pkg::FUNC_PIN, 4'h8);
		send_paced(beqa_pkg::FUNC_POLL, 4'h8);
		send_paced(beqa_pkg::FUNC_POLL, 4'h9);
		ticks(3);
		send_paced(beqa_pkg::FUNC_POLL, 4'h8);
		send_paced(beqa_pkg::FUNC_PIN, 4'h8);
		ticks(3);
		send_paced(beqa_pkg::FUNC_POLL, 4'h8);
		send_paced(beqa_pkg::FUNC_POLL, 4'h8);
		ticks(2);
		send_paced(beqa_pkg::FUNC_POLL, 4'h8);
		send_paced(beqa_pkg::FUNC_PIN, 4'hF);
		send_paced(beqa_pkg::FUNC_POLL, 4'hF);
		send_paced(beqa_pkg::FUNC_PIN, 4'h0);
		send_paced(beqa_pkg::FUNC_POLL, 4'h0);
		send_paced(beqa_pkg::FUNC_POP, 4'h5);
		send_paced(beqa_pkg::FUNC_POP, 4'h5);
	endtask

	// Largest delays: no repeat can fall due within the run
	task automatic test_delay_max();
		cfg_write(beqa_pkg::CFG_INITIAL_DELAY, 16'hFFFF);
		cfg_write(beqa_pkg::CFG_REPEAT_DELAY, 16'hFFFF);
		send_paced(beqa_pkg::FUNC_PIN, 4'h4);
		ticks(5);
		send_paced(beqa_pkg::FUNC_POLL, 4'h4);
		send_paced(beqa_pkg::FUNC_POP, 4'h0);
		send_paced(beqa_pkg::FUNC_PIN, 4'h0);
	endtask

	// A press held for a while with polls in between, then released
	task automatic hold_sequence();
		logic [beqa_pkg::PINS_W-1:0] p;
		int n_ticks;
		p = beqa_pkg::PINS_W'(1) << $urandom_range(0, beqa_pkg::PINS_W - 1);
		n_ticks = $urandom_range(0, 10);
		send_paced(beqa_pkg::FUNC_PIN, p);
		repeat (n_ticks) begin
			send_paced(beqa_pkg::FUNC_TICK, beqa_pkg::PINS_W'($urandom));
			if ($urandom_range(0, 9) < 6)
				send_paced(beqa_pkg::FUNC_POLL, p);
		end
		if ($urandom_range(0, 4) == 0)
			send_paced(beqa_pkg::FUNC_POLL, p ^ beqa_pkg::PINS_W'($urandom_range(1, 15)));
		repeat ($urandom_range(0, 2))
			send_paced(beqa_pkg::FUNC_POP, beqa_pkg::PINS_W'($urandom));
		if ($urandom_range(0, 1) == 0)
			send_paced(beqa_pkg::FUNC_PIN, beqa_pkg::PINS_W'($urandom));
	endtask

	// Random phases over several delay settings, extremes first
	task automatic test_random();
		logic [beqa_pkg::DELAY_W-1:0] first_sets[8];
		logic [beqa_pkg::DELAY_W-1:0] gap_sets[8];
		int target;
		first_sets = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd4, 16'd2, 16'd0};
		gap_sets   = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd3, 16'd1, 16'd6, 16'd2};
		first_sets[6] = beqa_pkg::DELAY_W'($urandom_range(0, 6));
		gap_sets[6]   = beqa_pkg::DELAY_W'($urandom_range(0, 6));
		first_sets[7] = beqa_pkg::DELAY_W'($urandom_range(0, 65535));
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(beqa_pkg::CFG_INITIAL_DELAY, first_sets[ph]);
			cfg_write(beqa_pkg::CFG_REPEAT_DELAY, gap_sets[ph]);
			target = n_items + 110;
			while (n_items < target) begin
				if ($urandom_range(0, 9) < 7)
					hold_sequence();
				else
					send_paced(beqa_pkg::func_t'($urandom_range(0, 3)),
						beqa_pkg::PINS_W'($urandom));
				// in phase 3, pauses mid-phase until the block has caught up
				if (ph == 3 && n_items >= target - 90 && n_items < target - 80)
					drain_reports();
			end
		end
	endtask

	initial begin
		int waited;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		func      <= beqa_pkg::FUNC_TICK;
		pins      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= beqa_pkg::CFG_INITIAL_DELAY;
		cfg_data  <= '0;
		held_presses.delete();
		pins_seen       = '0;
		deadline_ms     = '0;
		ms_now          = '0;
		first_repeat_ms = beqa_pkg::RESET_INITIAL_DELAY;
		repeat_gap_ms   = beqa_pkg::RESET_REPEAT_DELAY;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_deadline_and_reset_interval();
		test_queue_full();
		test_repeat_polls();
		test_delay_max();
		test_random();

		// Let the last reports out, within a bound
		start <= 1'b0;
		waited = 0;
		while (pending_reports.size() != 0 && waited < 50) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() != 0) begin
			$error("%0d results never arrived", pending_reports.size());
			fail_count++;
		end
		repeat (4) @(posedge clk);

		$display("Covered %0d items and %0d register writes:", n_items, n_cfg);
		$display("%0d auto-repeats and %0d presses popped.", n_repeats, n_pops);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/beqa_pkg.sv
hdl/button_event_queue_autorepeat_core.sv
hdl/beqa_checker.sv
sim/tb_button_event_queue_autorepeat_core.sv
